/* rtl/vcbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vcbp_pkg
// types and constants shared by the comment block parser
// ----------------------------------------------------------------------------
package vcbp_pkg;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // byte roles
  localparam logic [1:0] ROLE_FRAMING   = 2'd0;
  localparam logic [1:0] ROLE_KEY       = 2'd1;
  localparam logic [1:0] ROLE_SEPARATOR = 2'd2;
  localparam logic [1:0] ROLE_VALUE     = 2'd3;

  // block status
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // configuration register indexes
  typedef enum logic {
    CFG_MAX_ENTRY_COUNT  = 1'b0,
    CFG_MAX_ENTRY_LENGTH = 1'b1
  } vcbp_cfg_idx_t;

  localparam logic [15:0] MAX_ENTRY_COUNT_RST  = 16'd256;
  localparam logic [23:0] MAX_ENTRY_LENGTH_RST = 24'd65536;

  localparam logic [7:0]  SEPARATOR_CHAR   = 8'h3D;
  localparam logic [31:0] MIN_BLOCK_LENGTH = 32'd8;
  localparam logic [31:0] LENGTH_WORD_SIZE = 32'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] total_length;
    logic [7:0]  data_byte;
  } vcbp_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  role;
    logic        entry_end;
    logic        entry_keyless;
    logic [15:0] entry_number;
    logic [1:0]  status;
  } vcbp_out_t;

endpackage
`default_nettype wire

/* rtl/vorbis_comment_block_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vorbis_comment_block_parser_top
// byte-serial comment block parser that tags every byte with its role
// ----------------------------------------------------------------------------
// A start item opens a block of total_length bytes; data items then carry the
// block one byte at a time: a little-endian 32-bit vendor length, the vendor
// string (skipped), a 32-bit comment count and length-prefixed KEY=value
// entries. Each accepted item gives exactly one result item: the byte, its
// role (framing, key, separator, value), entry end and keyless flags, the
// entry index and the sticky status (busy, done, invalid). The block takes
// one item every clock cycle while in_stall is low; the whole parse step
// (length word assembly, bounds compares against the bytes left and the two
// limits, and the counter updates) sits between the item port and the result
// register. A two-deep output (result register plus skid register) keeps
// accepting while a result waits; in_stall is simply the skid register being
// full, so throughput drops only while the sink holds out_stall. Configuration
// writes are always ready and belong to idle periods.
// ----------------------------------------------------------------------------
module vorbis_comment_block_parser_top
  import vcbp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  // item input
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire vcbp_in_t      in_item,
  // result output
  output logic               out_valid,
  input  wire logic          out_stall,
  output vcbp_out_t          out_item,
  // configuration writes
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire vcbp_cfg_idx_t cfg_index,
  input  wire logic [23:0]   cfg_data
);

  // parse phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_VLEN   = 8'b0000_0010,
    PH_VENDOR = 8'b0000_0100,
    PH_COUNT  = 8'b0000_1000,
    PH_ELEN   = 8'b0001_0000,
    PH_ENTRY  = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } phase_t;

  // configuration registers
  logic [15:0] max_cnt_r;
  logic [23:0] max_len_r;

  // parser state
  phase_t      phase_r,     phase_nxt;
  logic [31:0] blk_left_r,  blk_left_nxt;   // bytes left in the block
  logic [23:0] asm_r,       asm_nxt;        // low three bytes of a length word
  logic [1:0]  idx_r,       idx_nxt;        // byte position in the length word
  logic [31:0] fld_left_r,  fld_left_nxt;   // bytes left in vendor or entry
  logic [15:0] ent_left_r,  ent_left_nxt;   // entries still to come
  logic [15:0] cur_ent_r,   cur_ent_nxt;    // index of the current entry
  logic        sep_seen_r,  sep_seen_nxt;
  logic [1:0]  status_r,    status_nxt;

  // output register and skid register
  logic        out_valid_r;
  vcbp_out_t   out_item_r;
  logic        skid_valid_r;
  vcbp_out_t   skid_item_r;

  logic        in_accept;
  logic        out_free;
  vcbp_out_t   res;

  // combinational helpers
  logic [31:0] blk_dec;
  logic [31:0] fld_dec;
  logic [31:0] len_val;
  logic [15:0] ent_dec;
  logic        blk_short;
  logic        do_finish;
  logic        want_len;
  phase_t      len_phase;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  assign blk_dec   = blk_left_r - 32'd1;
  assign fld_dec   = fld_left_r - 32'd1;
  assign ent_dec   = ent_left_r - 16'd1;
  // the last length byte arrives live, the other three come from the assembler
  assign len_val   = {in_item.data_byte, asm_r};
  // every consuming byte decrements the block count first
  assign blk_short = blk_dec < LENGTH_WORD_SIZE;

  // --------------------------------------------------------------------------
  // parse step for one item
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt    = phase_r;
    blk_left_nxt = blk_left_r;
    asm_nxt      = asm_r;
    idx_nxt      = idx_r;
    fld_left_nxt = fld_left_r;
    ent_left_nxt = ent_left_r;
    cur_ent_nxt  = cur_ent_r;
    sep_seen_nxt = sep_seen_r;
    status_nxt   = status_r;
    do_finish    = 1'b0;
    want_len     = 1'b0;
    len_phase    = PH_ELEN;

    res               = '0;

    if (in_accept) begin
      if (in_item.kind == KIND_START) begin
        // a start always abandons whatever block was open
        blk_left_nxt = in_item.total_length;
        asm_nxt      = '0;
        idx_nxt      = '0;
        fld_left_nxt = '0;
        ent_left_nxt = '0;
        cur_ent_nxt  = '0;
        sep_seen_nxt = 1'b0;
        if (in_item.total_length < MIN_BLOCK_LENGTH) begin
          phase_nxt  = PH_ERROR;
          status_nxt = ST_INVALID;
        end else begin
          phase_nxt  = PH_VLEN;
          status_nxt = ST_BUSY;
        end
      end else begin
        res.out_byte     = in_item.data_byte;
        res.entry_number = cur_ent_r;
        unique case (phase_r)
          PH_VLEN, PH_COUNT, PH_ELEN: begin
            blk_left_nxt = blk_dec;
            if (idx_r != 2'd3) begin
              idx_nxt = idx_r + 2'd1;
              unique case (idx_r)
                2'd0:    asm_nxt[7:0]   = in_item.data_byte;
                2'd1:    asm_nxt[15:8]  = in_item.data_byte;
                default: asm_nxt[23:16] = in_item.data_byte;
              endcase
            end else begin
              asm_nxt = '0;
              idx_nxt = '0;
              if (phase_r == PH_VLEN) begin
                if (len_val > blk_dec) begin
                  phase_nxt  = PH_ERROR;
                  status_nxt = ST_INVALID;
                end else if (len_val == 32'd0) begin
                  want_len  = 1'b1;
                  len_phase = PH_COUNT;
                end else begin
                  fld_left_nxt = len_val;
                  phase_nxt    = PH_VENDOR;
                end
              end else if (phase_r == PH_COUNT) begin
                if (len_val > {16'd0, max_cnt_r}) begin
                  phase_nxt  = PH_ERROR;
                  status_nxt = ST_INVALID;
                end else begin
                  ent_left_nxt = len_val[15:0];
                  cur_ent_nxt  = '0;
                  if (len_val[15:0] == 16'd0) begin
                    phase_nxt  = PH_DONE;
                    status_nxt = ST_DONE;
                  end else begin
                    want_len  = 1'b1;
                    len_phase = PH_ELEN;
                  end
                end
              end else begin
                if (len_val > blk_dec || len_val > {8'd0, max_len_r}) begin
                  phase_nxt  = PH_ERROR;
                  status_nxt = ST_INVALID;
                end else if (len_val == 32'd0) begin
                  // empty entry ends on its own length word
                  res.entry_end     = 1'b1;
                  res.entry_keyless = 1'b1;
                  do_finish         = 1'b1;
                end else begin
                  fld_left_nxt = len_val;
                  sep_seen_nxt = 1'b0;
                  phase_nxt    = PH_ENTRY;
                end
              end
            end
          end
          PH_VENDOR: begin
            blk_left_nxt = blk_dec;
            fld_left_nxt = fld_dec;
            if (fld_dec == 32'd0) begin
              want_len  = 1'b1;
              len_phase = PH_COUNT;
            end
          end
          PH_ENTRY: begin
            if (sep_seen_r) begin
              res.role = ROLE_VALUE;
            end else if (in_item.data_byte == SEPARATOR_CHAR) begin
              res.role     = ROLE_SEPARATOR;
              sep_seen_nxt = 1'b1;
            end else begin
              res.role = ROLE_KEY;
            end
            blk_left_nxt = blk_dec;
            fld_left_nxt = fld_dec;
            if (fld_dec == 32'd0) begin
              res.entry_end     = 1'b1;
              res.entry_keyless = !sep_seen_nxt;
              do_finish         = 1'b1;
            end
          end
          PH_IDLE, PH_DONE, PH_ERROR: begin
            // bytes outside an open block pass through untouched
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase

        if (do_finish) begin
          cur_ent_nxt  = cur_ent_r + 16'd1;
          ent_left_nxt = ent_dec;
          if (ent_dec == 16'd0) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_DONE;
          end else begin
            want_len  = 1'b1;
            len_phase = PH_ELEN;
          end
        end

        // a length word must still fit in the block
        if (want_len) begin
          if (blk_short) begin
            phase_nxt  = PH_ERROR;
            status_nxt = ST_INVALID;
          end else begin
            phase_nxt = len_phase;
            asm_nxt   = '0;
            idx_nxt   = '0;
          end
        end
      end
    end

    res.status = status_nxt;
  end

  // --------------------------------------------------------------------------
  // parser state and configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      blk_left_r <= '0;
      asm_r      <= '0;
      idx_r      <= '0;
      fld_left_r <= '0;
      ent_left_r <= '0;
      cur_ent_r  <= '0;
      sep_seen_r <= 1'b0;
      status_r   <= ST_BUSY;
      max_cnt_r  <= MAX_ENTRY_COUNT_RST;
      max_len_r  <= MAX_ENTRY_LENGTH_RST;
    end else begin
      phase_r    <= phase_nxt;
      blk_left_r <= blk_left_nxt;
      asm_r      <= asm_nxt;
      idx_r      <= idx_nxt;
      fld_left_r <= fld_left_nxt;
      ent_left_r <= ent_left_nxt;
      cur_ent_r  <= cur_ent_nxt;
      sep_seen_r <= sep_seen_nxt;
      status_r   <= status_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAX_ENTRY_COUNT:  max_cnt_r <= cfg_data[15:0];
          CFG_MAX_ENTRY_LENGTH: max_len_r <= cfg_data;
          default:              max_len_r <= max_len_r;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register with skid stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_r) begin
          // no item is taken while the skid register is full
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (in_accept) begin
        out_item_r <= res;
      end
    end else if (in_accept) begin
      skid_item_r <= res;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the skid register only fills behind a waiting result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item with the result register empty");

  // a short block is flagged invalid right away
  a_short_block : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.kind == KIND_START && in_item.total_length < MIN_BLOCK_LENGTH)
    |=> (phase_r == PH_ERROR && status_r == ST_INVALID))
    else $error("short block not flagged invalid");

  // inside an entry there is always a byte and an entry left to account for
  a_entry_counts : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ENTRY) |-> (fld_left_r != 32'd0 && ent_left_r != 16'd0))
    else $error("entry phase with exhausted counters");

  // terminal phases agree with the sticky status
  a_status_phase : assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_DONE) |-> (status_r == ST_DONE)) and
    ((phase_r == PH_ERROR) |-> (status_r == ST_INVALID)))
    else $error("status disagrees with parse phase");

endmodule
`default_nettype wire
